// ===== src/tsc_pkg.sv =====
package tsc_pkg;

  localparam int NUM_PROBES = 4;
  localparam int PROBE_W    = 2;
  localparam int CNT_CFG_W  = 3;
  localparam int POS_W      = 4;
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = 1;
  localparam int Q_CNT_W    = 2;

  localparam logic [POS_W-1:0] POS_TEMP_LO = 4'd0;
  localparam logic [POS_W-1:0] POS_TEMP_HI = 4'd1;
  localparam logic [POS_W-1:0] POS_CRC     = 4'd8;

  localparam logic [7:0]         CRC_POLY   = 8'h8C;
  localparam logic signed [15:0] NO_READING = 16'shF810;

  localparam logic OP_BYTE        = 1'b0;
  localparam logic OP_NO_PRESENCE = 1'b1;

  typedef enum logic [1:0] {
    ST_FRESH   = 2'd0,
    ST_CRC_BAD = 2'd1,
    ST_NO_PRES = 2'd2,
    ST_ABSENT  = 2'd3
  } status_e_t;

  typedef enum logic {
    CMD_FRAME  = 1'b0,
    CMD_NOPRES = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    logic               op;
    logic [PROBE_W-1:0] probe;
    logic [7:0]         data_byte;
  } in_word_t;

  typedef struct packed {
    logic [PROBE_W-1:0] probe_out;
    logic signed [15:0] temperature;
    logic [1:0]         status;
  } out_word_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [PROBE_W-1:0] probe;
    logic               crc_ok;
    logic signed [15:0] temp;
  } cmd_t;

  typedef struct packed {
    logic wr_en;
  } cq_ctl_t;

  function automatic logic [7:0] crc8_byte(logic [7:0] crc, logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
    end
    return v;
  endfunction

endpackage

// ===== src/temperature_scratchpad_checker.sv =====
// channel   ports                                  word
// input     push, full, in_word                    tsc_pkg::in_word_t
// result    empty, pop, out_word                   tsc_pkg::out_word_t
// config    cfg_we, cfg_wdata                      probes_present, 3 bits
//
// one input word per cycle while full is low; the word that closes a frame
// (crc byte or no-presence report) passes the command queue, then the lookup/store stage
// both sides hold two-entry queues; full rises only when the command queue is full
// reset: synchronous, active low; last values return to -127 degrees at once
module temperature_scratchpad_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  tsc_pkg::in_word_t             in_word,
  output logic                          empty,
  input  logic                          pop,
  output tsc_pkg::out_word_t            out_word,
  input  logic                          cfg_we,
  input  logic [tsc_pkg::CNT_CFG_W-1:0] cfg_wdata
);
  import tsc_pkg::*;

  cq_ctl_t cq_ctl;
  cmd_t    cmd_wr, cmd_rd;
  logic    cq_full, cq_empty, cq_rd;

  assign full = cq_full;

  tsc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .in_word  (in_word),
    .cq_ctl_o (cq_ctl),
    .cq_full  (cq_full),
    .cmd_o    (cmd_wr)
  );

  tsc_cmd_q u_cmd_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .cq_ctl_i (cq_ctl),
    .wr_data  (cmd_wr),
    .q_full   (cq_full),
    .q_empty  (cq_empty),
    .rd_en    (cq_rd),
    .rd_data  (cmd_rd)
  );

  tsc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cq_empty  (cq_empty),
    .cmd_i     (cmd_rd),
    .cq_rd     (cq_rd),
    .empty     (empty),
    .pop       (pop),
    .out_word  (out_word)
  );

endmodule

// ===== src/tsc_front.sv =====
module tsc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tsc_pkg::in_word_t in_word,
  output tsc_pkg::cq_ctl_t  cq_ctl_o,
  input  logic              cq_full,
  output tsc_pkg::cmd_t     cmd_o
);
  import tsc_pkg::*;

  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [7:0]         crc_r, crc_nxt;
  logic [7:0]         lo_r, lo_nxt;
  logic [7:0]         hi_r, hi_nxt;
  logic [PROBE_W-1:0] probe_r, probe_nxt;
  logic               accept;
  logic [7:0]         crc_in;

  assign accept = push && !cq_full;
  assign crc_in = (pos_r == POS_TEMP_LO) ? 8'd0 : crc_r;

  always_comb begin
    pos_nxt   = pos_r;
    crc_nxt   = crc_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    probe_nxt = probe_r;
    cmd_o.kind   = CMD_FRAME;
    cmd_o.probe  = probe_r;
    cmd_o.crc_ok = (crc_r == in_word.data_byte);
    cmd_o.temp   = signed'({hi_r, lo_r});
    cq_ctl_o.wr_en = 1'b0;
    if (accept) begin
      if (in_word.op == OP_NO_PRESENCE) begin
        pos_nxt        = '0;
        crc_nxt        = '0;
        cmd_o.kind     = CMD_NOPRES;
        cmd_o.probe    = in_word.probe;
        cq_ctl_o.wr_en = 1'b1;
      end else if (pos_r == POS_CRC) begin
        pos_nxt        = '0;
        crc_nxt        = '0;
        cq_ctl_o.wr_en = 1'b1;
      end else begin
        if (pos_r == POS_TEMP_LO) begin
          probe_nxt = in_word.probe;
          lo_nxt    = in_word.data_byte;
        end
        if (pos_r == POS_TEMP_HI) begin
          hi_nxt = in_word.data_byte;
        end
        crc_nxt = crc8_byte(crc_in, in_word.data_byte);
        pos_nxt = pos_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      crc_r   <= '0;
      lo_r    <= '0;
      hi_r    <= '0;
      probe_r <= '0;
    end else begin
      pos_r   <= pos_nxt;
      crc_r   <= crc_nxt;
      lo_r    <= lo_nxt;
      hi_r    <= hi_nxt;
      probe_r <= probe_nxt;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_CRC) else $error("byte position past crc byte");

  a_frame_close: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_word.op == OP_BYTE && pos_r == POS_CRC |=> pos_r == '0 && crc_r == '0)
    else $error("frame not closed after crc byte");

endmodule

// ===== src/tsc_cmd_q.sv =====
module tsc_cmd_q (
  input  logic             clk,
  input  logic             rst_n,
  input  tsc_pkg::cq_ctl_t cq_ctl_i,
  input  tsc_pkg::cmd_t    wr_data,
  output logic             q_full,
  output logic             q_empty,
  input  logic             rd_en,
  output tsc_pkg::cmd_t    rd_data
);
  import tsc_pkg::*;

  cmd_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wp_r, wp_nxt;
  logic [Q_PTR_W-1:0] rp_r, rp_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               do_wr, do_rd;

  assign q_full  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign q_empty = (cnt_r == '0);
  assign do_wr   = cq_ctl_i.wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = mem_r[rp_r];

  always_comb begin
    wp_nxt  = do_wr ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_rd ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + Q_CNT_W'(do_wr) - Q_CNT_W'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= Q_CNT_W'(Q_DEPTH)) else $error("command queue overflow");

endmodule

// ===== src/tsc_back.sv =====
module tsc_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [tsc_pkg::CNT_CFG_W-1:0] cfg_wdata,
  input  logic                         cq_empty,
  input  tsc_pkg::cmd_t                cmd_i,
  output logic                         cq_rd,
  output logic                         empty,
  input  logic                         pop,
  output tsc_pkg::out_word_t           out_word
);
  import tsc_pkg::*;

  logic [CNT_CFG_W-1:0] present_cnt_r;
  logic signed [15:0]   last_r [NUM_PROBES];
  out_word_t            oq_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wp_r, rp_r;
  logic [Q_CNT_W-1:0]   cnt_r;
  logic                 take, popped, present, store;
  logic signed [15:0]   held;
  out_word_t            res;

  assign take     = !cq_empty && (cnt_r != Q_CNT_W'(Q_DEPTH));
  assign cq_rd    = take;
  assign empty    = (cnt_r == '0);
  assign popped   = pop && !empty;
  assign out_word = oq_r[rp_r];

  assign present = (CNT_CFG_W'(cmd_i.probe) < present_cnt_r)
                && (32'(cmd_i.probe) < NUM_PROBES);
  assign held    = last_r[cmd_i.probe];
  assign store   = take && cmd_i.kind == CMD_FRAME && present && cmd_i.crc_ok;

  always_comb begin
    res.probe_out   = cmd_i.probe;
    res.temperature = NO_READING;
    res.status      = ST_ABSENT;
    if (present) begin
      if (cmd_i.kind == CMD_NOPRES) begin
        res.temperature = held;
        res.status      = ST_NO_PRES;
      end else if (cmd_i.crc_ok) begin
        res.temperature = cmd_i.temp;
        res.status      = ST_FRESH;
      end else begin
        res.temperature = held;
        res.status      = ST_CRC_BAD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      oq_r[wp_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_cnt_r <= '0;
      wp_r          <= '0;
      rp_r          <= '0;
      cnt_r         <= '0;
      for (int i = 0; i < NUM_PROBES; i++) begin
        last_r[i] <= NO_READING;
      end
    end else begin
      if (cfg_we) begin
        present_cnt_r <= cfg_wdata;
      end
      if (store) begin
        last_r[cmd_i.probe] <= cmd_i.temp;
      end
      if (take) begin
        wp_r <= wp_r + 1'b1;
      end
      if (popped) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + Q_CNT_W'(take) - Q_CNT_W'(popped);
    end
  end

  a_oq_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= Q_CNT_W'(Q_DEPTH)) else $error("result queue overflow");

  a_store: assert property (@(posedge clk) disable iff (!rst_n)
    store |=> last_r[$past(cmd_i.probe)] == $past(cmd_i.temp))
    else $error("fresh temperature not stored");

  a_fresh_src: assert property (@(posedge clk) disable iff (!rst_n)
    take && res.status == ST_FRESH |-> cmd_i.kind == CMD_FRAME && cmd_i.crc_ok)
    else $error("fresh result without good crc");

endmodule
